### src/periodic_task_deadline_monitor_macros.svh
// Assertion macros used by the deadline monitor checker.
`ifndef PERIODIC_TASK_DEADLINE_MONITOR_MACROS_SVH
`define PERIODIC_TASK_DEADLINE_MONITOR_MACROS_SVH

// Check a property while out of reset.
`define PTDM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PTDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ptdm_pkg.sv
// Types and constants of the periodic task deadline monitor.
package ptdm_pkg;

    localparam logic [31:0] HALF_RANGE     = 32'h8000_0000;
    localparam logic [30:0] PERIOD_RESET   = 31'd1000;
    localparam int          PADDR_W        = 3;
    localparam logic        REG_PERIOD_IDX = 1'b0;

    typedef struct packed {
        logic [31:0] run_start;
        logic [31:0] run_finish;
        logic        resync_next;
    } t_run;

    typedef struct packed {
        logic        seen_first;
        logic [31:0] prev_start;
        logic [31:0] expected_release;
        logic [31:0] jitter_peak;
        logic [30:0] lateness_peak;
        logic [30:0] overrun_peak;
        logic [31:0] misses;
        logic [31:0] invalids;
    } t_state;

    typedef struct packed {
        logic        sample_ok;
        logic [30:0] measured_period_us;
        logic [31:0] period_err;
        logic [31:0] release_err;
        logic [30:0] exec_time;
        logic [30:0] late_by;
        logic [31:0] due_time;
        logic [31:0] max_jitter_us;
        logic [30:0] max_lateness_us;
        logic [30:0] max_overrun_us;
        logic [31:0] miss_count;
        logic [31:0] invalid_count;
    } t_result;

endpackage

### src/ptdm_calc.sv
// Per-run timing math: result fields and next monitor state.
module ptdm_calc (
    input  ptdm_pkg::t_run    i_run,
    input  ptdm_pkg::t_state  i_state,
    input  logic [30:0]       i_period_us,
    output ptdm_pkg::t_result o_result,
    output ptdm_pkg::t_state  o_state
);
    import ptdm_pkg::*;

    logic [31:0] p32;
    logic        first;
    logic [31:0] exec_raw;
    logic        exec_ok;
    logic [31:0] per_raw;
    logic        per_ok;
    logic [31:0] exp_rel;
    logic [31:0] perr;
    logic [31:0] jitter;
    logic [31:0] rerr;
    logic        rel_ok;
    logic [30:0] lateness;
    logic [31:0] deadline;
    logic [31:0] draw;
    logic        dl_ok;
    logic [30:0] overrun;
    logic        valid;

    assign p32      = {1'b0, i_period_us};
    assign first    = !i_state.seen_first;
    assign exec_raw = i_run.run_finish - i_run.run_start;
    assign exec_ok  = !exec_raw[31];
    assign per_raw  = i_run.run_start - i_state.prev_start;
    assign per_ok   = !first && !per_raw[31];
    assign exp_rel  = first ? i_run.run_start : (i_state.expected_release + p32);
    assign perr     = per_raw - p32;
    assign jitter   = perr[31] ? (32'd0 - perr) : perr;
    assign rerr     = i_run.run_start - exp_rel;
    assign rel_ok   = per_ok && (rerr != HALF_RANGE);
    assign lateness = (rel_ok && rerr != 32'd0 && !rerr[31]) ? rerr[30:0] : 31'd0;
    assign deadline = exp_rel + p32;
    assign draw     = i_run.run_finish - deadline;
    // Deadline check only when execution and (for later runs) release checks hold.
    assign dl_ok    = exec_ok && (first || rel_ok) && (draw != HALF_RANGE);
    assign overrun  = (dl_ok && draw != 32'd0 && !draw[31]) ? draw[30:0] : 31'd0;
    assign valid    = exec_ok && dl_ok && (first || (per_ok && rel_ok));

    always_comb begin
        o_state.seen_first       = 1'b1;
        o_state.prev_start       = i_run.run_start;
        o_state.expected_release = (i_run.resync_next || !valid) ? i_run.run_start : exp_rel;
        o_state.jitter_peak      = (per_ok && jitter > i_state.jitter_peak)
                                   ? jitter : i_state.jitter_peak;
        o_state.lateness_peak    = (rel_ok && lateness > i_state.lateness_peak)
                                   ? lateness : i_state.lateness_peak;
        o_state.overrun_peak     = (overrun > i_state.overrun_peak)
                                   ? overrun : i_state.overrun_peak;
        o_state.misses           = (overrun != 31'd0) ? (i_state.misses + 32'd1)
                                   : i_state.misses;
        o_state.invalids         = valid ? i_state.invalids : (i_state.invalids + 32'd1);
    end

    always_comb begin
        o_result.sample_ok          = valid;
        o_result.measured_period_us = per_ok ? per_raw[30:0] : 31'd0;
        o_result.period_err         = per_ok ? perr : 32'd0;
        o_result.release_err        = rel_ok ? rerr : 32'd0;
        o_result.exec_time          = exec_ok ? exec_raw[30:0] : 31'd0;
        o_result.late_by            = overrun;
        o_result.due_time           = valid ? deadline : (i_run.run_start + p32);
        o_result.max_jitter_us      = o_state.jitter_peak;
        o_result.max_lateness_us    = o_state.lateness_peak;
        o_result.max_overrun_us     = o_state.overrun_peak;
        o_result.miss_count         = o_state.misses;
        o_result.invalid_count      = o_state.invalids;
    end

endmodule

### src/periodic_task_deadline_monitor.sv
// Top level of the periodic task deadline monitor.
//
// Usage:
//   - Input channel (i_in_valid / o_in_ready) carries one beat per task run:
//     start and finish timestamps plus a resync request.
//   - Output channel (o_out_valid / i_out_ready) returns one result beat per
//     run, in order: validity, period, errors, execution time, overrun, deadline,
//     the three running maxima and the miss and invalid counters.
//   - APB port holds the nominal period at byte address 0 (reset 1000 us).
//     Write it only while no run is in flight.
// Path: an accepted beat lands in the input register, is evaluated
//   combinationally and moves to the result register once the output slot is free.
// Throughput: one run per cycle unless the output stalls. The run state
//   (previous start, expected release, peaks, counters) is updated in the same
//   cycle the result is registered, so the next run sees it at once.
// Stall: while a result waits, the input register still takes a beat; when
//   both are full, o_in_ready follows i_out_ready.
// Reset: synchronous, active low; clears the valid flags of both channel
//   registers and the run state, and returns the period to its default.
module periodic_task_deadline_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptdm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // run beats
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [31:0]                   i_run_start,
    input  logic [31:0]                   i_run_finish,
    input  logic                          i_resync_next,
    // result beats
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_sample_ok,
    output logic [30:0]                   o_measured_period_us,
    output logic signed [31:0]            o_period_err,
    output logic signed [31:0]            o_release_err,
    output logic [30:0]                   o_exec_time,
    output logic [30:0]                   o_late_by,
    output logic [31:0]                   o_due_time,
    output logic [31:0]                   o_max_jitter_us,
    output logic [30:0]                   o_max_lateness_us,
    output logic [30:0]                   o_max_overrun_us,
    output logic [31:0]                   o_miss_count,
    output logic [31:0]                   o_invalid_count
);
    import ptdm_pkg::*;

    logic [30:0] r_period;
    t_run        r_in;
    logic        r_in_valid;
    t_state      r_state;
    t_result     r_out;
    logic        r_out_valid;

    t_state      n_state;
    t_result     n_out;
    logic        advance;
    logic        in_beat;
    logic        cfg_wr;

    // APB: zero wait states, single period register at index 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1] == REG_PERIOD_IDX);
    assign prdata = (paddr[PADDR_W-1] == REG_PERIOD_IDX) ? {1'b0, r_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (cfg_wr) begin
            r_period <= pwdata[30:0];
        end
    end

    // Advance the held run into the result register when the output slot
    // is free or being drained this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_beat    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in.run_start   <= i_run_start;
            r_in.run_finish  <= i_run_finish;
            r_in.resync_next <= i_resync_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    ptdm_calc u_calc (
        .i_run       (r_in),
        .i_state     (r_state),
        .i_period_us (r_period),
        .o_result    (n_out),
        .o_state     (n_state)
    );

    // Commit run state together with the result so back-to-back runs chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_sample_ok          = r_out.sample_ok;
    assign o_measured_period_us = r_out.measured_period_us;
    assign o_period_err         = r_out.period_err;
    assign o_release_err        = r_out.release_err;
    assign o_exec_time          = r_out.exec_time;
    assign o_late_by            = r_out.late_by;
    assign o_due_time           = r_out.due_time;
    assign o_max_jitter_us      = r_out.max_jitter_us;
    assign o_max_lateness_us    = r_out.max_lateness_us;
    assign o_max_overrun_us     = r_out.max_overrun_us;
    assign o_miss_count         = r_out.miss_count;
    assign o_invalid_count      = r_out.invalid_count;

endmodule

### src/ptdm_checker.sv
// Port-level checker for the deadline monitor, bound to the top level.
`include "periodic_task_deadline_monitor_macros.svh"

module ptdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_sample_ok,
    input logic [30:0] o_late_by,
    input logic [30:0] o_max_overrun_us,
    input logic [31:0] o_invalid_count
);

    // A stalled result beat stays valid and keeps its invalid count.
    `PTDM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_invalid_count), "result beat dropped or changed while stalled")

    // An overrun is only reported for a sample that passed every check.
    `PTDM_ASSERT(a_overrun_valid, i_clk, i_rst_n, o_out_valid && (o_late_by != 31'd0) |-> o_sample_ok, "overrun reported on invalid sample")

    // The reported peak already includes this run's overrun.
    `PTDM_ASSERT(a_overrun_peak, i_clk, i_rst_n, o_out_valid |-> (o_late_by <= o_max_overrun_us), "overrun above its running maximum")

    // Reset empties both channel registers.
    `PTDM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready, "channels not empty after reset")

endmodule

bind periodic_task_deadline_monitor ptdm_checker u_ptdm_checker (.*);
